// ===== src/canled_pkg.sv =====
`default_nettype none

package canled_pkg;

    // Width of the elapsed time field; the accumulator holds one tick less a
    // microsecond plus a full elapsed value, so one extra bit is enough.
    localparam int ELAPSED_WIDTH = 20;
    localparam int ACC_WIDTH     = ELAPSED_WIDTH + 1;
    localparam int TICK_US       = 50000;
    localparam int DIFF_WIDTH    = 16;
    localparam int LIMIT_WIDTH   = 32;
    localparam int NS_WIDTH      = 3;

    // pattern byte bit positions
    localparam int BIT_FLICKER = 0;
    localparam int BIT_BLINK   = 1;
    localparam int BIT_FLASH1  = 2;
    localparam int BIT_FLASH2  = 3;
    localparam int BIT_FLASH3  = 4;
    localparam int BIT_FLASH4  = 5;
    localparam int BIT_IND     = 7;

    localparam logic [3:0] FLASHES_1 = 4'd1;
    localparam logic [3:0] FLASHES_2 = 4'd2;
    localparam logic [3:0] FLASHES_3 = 4'd3;
    localparam logic [3:0] FLASHES_4 = 4'd4;

    localparam logic [NS_WIDTH-1:0] NS_INIT    = 3'd0;
    localparam logic [NS_WIDTH-1:0] NS_PREOP   = 3'd1;
    localparam logic [NS_WIDTH-1:0] NS_OPER    = 3'd2;
    localparam logic [NS_WIDTH-1:0] NS_STOPPED = 3'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic tick;
    } cmd_t;

    typedef struct packed {
        logic tick_due;
    } status_t;

    typedef struct packed {
        logic [3:0] count;
        logic       red;
        logic       green;
    } flash_t;

    // One slow step of an n-flash counter; period is 2n+4 steps, odd steps
    // light red, even steps up to 2n light green, the rest is the pause.
    function automatic flash_t flash_step(input logic [3:0] cnt, input logic [3:0] flashes);
        flash_t     res;
        logic [4:0] c;
        logic [4:0] double_n;
        logic [4:0] period;
        c        = {1'b0, cnt} + 5'd1;
        double_n = {flashes, 1'b0};
        period   = double_n + 5'd4;
        res      = '0;
        if (c >= period)
        begin
            res.count = 4'd0;
        end
        else
        begin
            res.count = c[3:0];
            if (c <= double_n)
            begin
                if (c[0])
                begin
                    res.red = 1'b1;
                end
                else
                begin
                    res.green = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/canled_ctrl.sv =====
`default_nettype none

module canled_ctrl
    import canled_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cmd_t         cmd,
    input  wire status_t status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (!status.tick_due)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_TICK:
            begin
                cmd.tick = status.tick_due;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a beat is never offered while ticks are still owed
    a_out_settled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !status.tick_due)
        else $error("result offered with tick pending");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.tick))
        else $error("load and tick in the same cycle");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");
`endif

endmodule

`default_nettype wire

// ===== src/canled_dp.sv =====
`default_nettype none

module canled_dp
    import canled_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output status_t                       status,
    input  wire logic [ELAPSED_WIDTH-1:0] elapsed_us,
    input  wire logic [NS_WIDTH-1:0]      node_state,
    input  wire logic                     lss_config,
    input  wire logic                     bus_off,
    input  wire logic                     bus_warning,
    input  wire logic                     pdo_error,
    input  wire logic                     sync_error,
    input  wire logic                     heartbeat_error,
    input  wire logic                     other_error,
    input  wire logic                     firmware_loading,
    input  wire logic [LIMIT_WIDTH-1:0]   wake_limit_us,
    output logic [7:0]                    red_patterns,
    output logic [7:0]                    green_patterns,
    output logic [LIMIT_WIDTH-1:0]        wake_next_us
);

    logic [ACC_WIDTH-1:0]   acc_reg;
    logic [ACC_WIDTH-1:0]   acc_next;
    logic [1:0]             slow_phase_reg;
    logic [1:0]             slow_phase_next;
    logic [2:0]             flash1_reg;
    logic [2:0]             flash1_next;
    logic [2:0]             flash2_reg;
    logic [2:0]             flash2_next;
    logic [3:0]             flash3_reg;
    logic [3:0]             flash3_next;
    logic [3:0]             flash4_reg;
    logic [3:0]             flash4_next;
    logic [7:0]             red_byte_reg;
    logic [7:0]             red_byte_next;
    logic [7:0]             green_byte_reg;
    logic [7:0]             green_byte_next;

    // item fields held for the tick loop
    logic [NS_WIDTH-1:0]    ns_reg;
    logic                   lss_reg;
    logic                   boff_reg;
    logic                   bwarn_reg;
    logic                   pdo_reg;
    logic                   sync_reg;
    logic                   hb_reg;
    logic                   oth_reg;
    logic                   fw_reg;
    logic [LIMIT_WIDTH-1:0] limit_reg;

    flash_t                 f1;
    flash_t                 f2;
    flash_t                 f3;
    flash_t                 f4;
    logic [7:0]             rd;
    logic [7:0]             gr;
    logic                   rind;
    logic                   gind;
    logic [ACC_WIDTH-1:0]   acc_left;
    logic [DIFF_WIDTH-1:0]  diff;

    assign status.tick_due = (acc_reg >= ACC_WIDTH'(TICK_US));

    // one tick's pattern update
    always_comb
    begin
        slow_phase_next = slow_phase_reg + 2'd1;
        f1 = flash_step({1'b0, flash1_reg}, FLASHES_1);
        f2 = flash_step({1'b0, flash2_reg}, FLASHES_2);
        f3 = flash_step(flash3_reg, FLASHES_3);
        f4 = flash_step(flash4_reg, FLASHES_4);
        if (slow_phase_next == 2'd0)
        begin
            rd = '0;
            gr = '0;
            if (!red_byte_reg[BIT_BLINK])
            begin
                rd[BIT_BLINK] = 1'b1;
            end
            else
            begin
                gr[BIT_BLINK] = 1'b1;
            end
            rd[BIT_FLASH1] = f1.red;
            gr[BIT_FLASH1] = f1.green;
            rd[BIT_FLASH2] = f2.red;
            gr[BIT_FLASH2] = f2.green;
            rd[BIT_FLASH3] = f3.red;
            gr[BIT_FLASH3] = f3.green;
            rd[BIT_FLASH4] = f4.red;
            gr[BIT_FLASH4] = f4.green;
            flash1_next = f1.count[2:0];
            flash2_next = f2.count[2:0];
            flash3_next = f3.count;
            flash4_next = f4.count;
        end
        else
        begin
            rd = red_byte_reg;
            gr = green_byte_reg;
            rd[BIT_FLICKER] = 1'b0;
            rd[BIT_IND]     = 1'b0;
            gr[BIT_FLICKER] = 1'b0;
            gr[BIT_IND]     = 1'b0;
            flash1_next = flash1_reg;
            flash2_next = flash2_reg;
            flash3_next = flash3_reg;
            flash4_next = flash4_reg;
        end
        if (!red_byte_reg[BIT_FLICKER])
        begin
            rd[BIT_FLICKER] = 1'b1;
        end
        else
        begin
            gr[BIT_FLICKER] = 1'b1;
        end

        priority if (boff_reg)              rind = 1'b1;
        else if (ns_reg == NS_INIT)         rind = rd[BIT_FLICKER];
        else if (pdo_reg)                   rind = rd[BIT_FLASH4];
        else if (sync_reg)                  rind = rd[BIT_FLASH3];
        else if (hb_reg)                    rind = rd[BIT_FLASH2];
        else if (bwarn_reg)                 rind = rd[BIT_FLASH1];
        else if (oth_reg)                   rind = rd[BIT_BLINK];
        else                                rind = 1'b0;

        priority if (lss_reg)               gind = gr[BIT_FLICKER];
        else if (fw_reg)                    gind = gr[BIT_FLASH3];
        else if (ns_reg == NS_STOPPED)      gind = gr[BIT_FLASH1];
        else if (ns_reg == NS_PREOP)        gind = gr[BIT_BLINK];
        else if (ns_reg == NS_OPER)         gind = 1'b1;
        else                                gind = 1'b0;

        red_byte_next   = rd;
        green_byte_next = gr;
        red_byte_next[BIT_IND]   = rind;
        green_byte_next[BIT_IND] = gind;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.load)
        begin
            acc_next = acc_reg + ACC_WIDTH'(elapsed_us);
        end
        else if (cmd.tick)
        begin
            acc_next = acc_reg - ACC_WIDTH'(TICK_US);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            slow_phase_reg <= '0;
            flash1_reg     <= '0;
            flash2_reg     <= '0;
            flash3_reg     <= '0;
            flash4_reg     <= '0;
            red_byte_reg   <= '0;
            green_byte_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.tick)
            begin
                slow_phase_reg <= slow_phase_next;
                flash1_reg     <= flash1_next;
                flash2_reg     <= flash2_next;
                flash3_reg     <= flash3_next;
                flash4_reg     <= flash4_next;
                red_byte_reg   <= red_byte_next;
                green_byte_reg <= green_byte_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ns_reg    <= node_state;
            lss_reg   <= lss_config;
            boff_reg  <= bus_off;
            bwarn_reg <= bus_warning;
            pdo_reg   <= pdo_error;
            sync_reg  <= sync_error;
            hb_reg    <= heartbeat_error;
            oth_reg   <= other_error;
            fw_reg    <= firmware_loading;
            limit_reg <= wake_limit_us;
        end
    end

    // accumulator is below one tick whenever the result is read
    assign acc_left = ACC_WIDTH'(TICK_US) - acc_reg;
    assign diff     = acc_left[DIFF_WIDTH-1:0];

    always_comb
    begin
        if (limit_reg > LIMIT_WIDTH'(diff))
        begin
            wake_next_us = LIMIT_WIDTH'(diff);
        end
        else
        begin
            wake_next_us = limit_reg;
        end
    end

    assign red_patterns   = red_byte_reg;
    assign green_patterns = green_byte_reg;

`ifndef SYNTHESIS
    a_tick_needs_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick |-> status.tick_due)
        else $error("tick issued with accumulator below one tick");

    a_slow_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick |=> slow_phase_reg == $past(slow_phase_reg) + 2'd1)
        else $error("slow phase did not advance on tick");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.load && !cmd.tick |=> $stable(acc_reg))
        else $error("accumulator changed without a command");

    a_flicker_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick |=> red_byte_reg[BIT_FLICKER] != $past(red_byte_reg[BIT_FLICKER]))
        else $error("flicker phase did not toggle on tick");
`endif

endmodule

`default_nettype wire

// ===== src/canopen_indicator_led_generator.sv =====
`default_nettype none

// Indicator LED generator for the red ERROR and green RUN LEDs. Each input beat
// carries the microseconds elapsed since the last beat plus node state and
// error flags; the time is accumulated and every 50 ms of it is one tick that
// steps the flicker, blink and flash patterns and re-picks both indicators.
// Ticks run one per clock in the tick loop, and a 20-bit elapsed value brings
// up to 21 ticks per item; the next input beat can be taken in the cycle after
// the result beat. One item is in flight at a time; in_ready is low from
// acceptance until the result beat is taken. If an item brings no tick,
// patterns and indicators repeat their last values, and wake_next_us gives
// the smaller of wake_limit_us and the time to the next tick.
module canopen_indicator_led_generator
    import canled_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [ELAPSED_WIDTH-1:0] elapsed_us,
    input  wire logic [NS_WIDTH-1:0]      node_state,
    input  wire logic                     lss_config,
    input  wire logic                     bus_off,
    input  wire logic                     bus_warning,
    input  wire logic                     pdo_error,
    input  wire logic                     sync_error,
    input  wire logic                     heartbeat_error,
    input  wire logic                     other_error,
    input  wire logic                     firmware_loading,
    input  wire logic [LIMIT_WIDTH-1:0]   wake_limit_us,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          red_indicator,
    output logic                          green_indicator,
    output logic [7:0]                    red_patterns,
    output logic [7:0]                    green_patterns,
    output logic [LIMIT_WIDTH-1:0]        wake_next_us
);

    cmd_t    cmd;
    status_t status;

    canled_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    canled_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .elapsed_us       (elapsed_us),
        .node_state       (node_state),
        .lss_config       (lss_config),
        .bus_off          (bus_off),
        .bus_warning      (bus_warning),
        .pdo_error        (pdo_error),
        .sync_error       (sync_error),
        .heartbeat_error  (heartbeat_error),
        .other_error      (other_error),
        .firmware_loading (firmware_loading),
        .wake_limit_us    (wake_limit_us),
        .red_patterns     (red_patterns),
        .green_patterns   (green_patterns),
        .wake_next_us     (wake_next_us)
    );

    assign red_indicator   = red_patterns[BIT_IND];
    assign green_indicator = green_patterns[BIT_IND];

endmodule

`default_nettype wire
